FILE: rtl/core/pit_pkg.sv
package pit_pkg;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pit_adv_t;

	// nearest integer to sqrt(2^(2*frac-3)), the half-height r in grid steps
	function automatic int unsigned grid_r(input int unsigned frac);
		logic [63:0] n;
		logic [63:0] s;
		logic [63:0] t;
		n = 64'd1 << (2 * frac - 3);
		s = '0;
		for (int b = 31; b >= 0; b--) begin
			t = s | (64'd1 << b);
			if (t * t <= n) begin
				s = t;
			end
		end
		if (n - s * s > s) begin
			s = s + 64'd1;
		end
		return 32'(s);
	endfunction

endpackage

FILE: rtl/core/pit_pt_if.sv
interface pit_pt_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

FILE: rtl/core/pit_res_if.sv
interface pit_res_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink   (input valid, input inside_res, output ready);
endinterface

FILE: rtl/core/pit_prod.sv
module pit_prod #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 20
) (
	input  logic                                     clk,
	input  pit_pkg::pit_adv_t                        adv,
	input  logic signed [COORD_WIDTH-1:0]            x,
	input  logic signed [COORD_WIDTH-1:0]            y,
	input  logic signed [COORD_WIDTH-1:0]            z,
	output logic signed [COORD_WIDTH+FRAC_BITS-1:0]  p_s2,
	output logic signed [COORD_WIDTH+FRAC_BITS-1:0]  q_s2,
	output logic signed [COORD_WIDTH+FRAC_BITS-1:0]  zs_s2
);
	import pit_pkg::*;

	localparam int PW = COORD_WIDTH + FRAC_BITS;
	localparam logic signed [FRAC_BITS-1:0] R = FRAC_BITS'(grid_r(FRAC_BITS));

	logic signed [COORD_WIDTH-1:0] x_s1;
	logic signed [COORD_WIDTH-1:0] y_s1;
	logic signed [COORD_WIDTH-1:0] z_s1;
	logic signed [PW-1:0]          p_d;
	logic signed [PW-1:0]          q_d;
	logic signed [PW-1:0]          zs_d;

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			x_s1 <= x;
			y_s1 <= y;
			z_s1 <= z;
		end
	end

	// r*x, r*y and h*z, with h a power of two
	assign p_d  = PW'(x_s1) * PW'(R);
	assign q_d  = PW'(y_s1) * PW'(R);
	assign zs_d = PW'(z_s1) <<< (FRAC_BITS - 1);

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			p_s2  <= p_d;
			q_s2  <= q_d;
			zs_s2 <= zs_d;
		end
	end
endmodule

FILE: rtl/core/pit_offs.sv
module pit_offs #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 20,
	parameter int AW          = 50
) (
	input  logic                                    clk,
	input  pit_pkg::pit_adv_t                       adv,
	input  logic signed [COORD_WIDTH+FRAC_BITS-1:0] p,
	input  logic signed [COORD_WIDTH+FRAC_BITS-1:0] q,
	input  logic signed [COORD_WIDTH+FRAC_BITS-1:0] zs,
	output logic signed [AW-1:0]                    tp_s3,
	output logic signed [AW-1:0]                    tq_s3,
	output logic signed [AW-1:0]                    d1_s3,
	output logic signed [AW-1:0]                    nd1_s3,
	output logic signed [AW-1:0]                    d2_s3,
	output logic signed [AW-1:0]                    nd2_s3
);
	import pit_pkg::*;

	// r*h
	localparam logic signed [AW-1:0] K = AW'(grid_r(FRAC_BITS)) <<< (FRAC_BITS - 1);

	logic signed [AW-1:0] pw;
	logic signed [AW-1:0] qw;
	logic signed [AW-1:0] zw;

	assign pw = AW'(p);
	assign qw = AW'(q);
	assign zw = AW'(zs);

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			tp_s3  <= pw <<< 1;
			tq_s3  <= qw <<< 1;
			d1_s3  <= zw - K;
			nd1_s3 <= K - zw;
			d2_s3  <= zw + K;
			nd2_s3 <= -zw - K;
		end
	end
endmodule

FILE: rtl/core/pit_cmp.sv
module pit_cmp #(
	parameter int AW = 50
) (
	input  logic                 clk,
	input  pit_pkg::pit_adv_t    adv,
	input  logic signed [AW-1:0] tp,
	input  logic signed [AW-1:0] tq,
	input  logic signed [AW-1:0] d1,
	input  logic signed [AW-1:0] nd1,
	input  logic signed [AW-1:0] d2,
	input  logic signed [AW-1:0] nd2,
	output logic                 inside_s4
);
	import pit_pkg::*;

	logic ge_a;
	logic ge_b;
	logic ge_c;
	logic ge_d;

	// face tests: fA = 2P-D1, fB = -2P-D1, fC = 2Q+D2, fD = -2Q+D2
	assign ge_a = tp >= d1;
	assign ge_b = tp <= nd1;
	assign ge_c = tq >= nd2;
	assign ge_d = tq <= d2;

	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			inside_s4 <= ge_a & ge_b & ge_c & ge_d;
		end
	end
endmodule

FILE: rtl/core/point_in_tetrahedron_test_top.sv
// Tests whether a signed fixed-point point (COORD_WIDTH bits, FRAC_BITS fraction
// bits) lies inside the regular tetrahedron with corners (+-1/2, 0, -r) and
// (0, +-1/2, +r), r = 1/(2*sqrt 2) on the grid; points on a face, edge or corner
// count as inside. Each beat on pt gives exactly one beat on res, in order. The
// block is a four-stage pipeline (input register, constant multiplies, offset
// adds, face compares into the output register): it takes one point every
// cycle while no stall on res has backed up to pt. A stall on res holds every
// stage in place; an empty stage still fills behind it.
module point_in_tetrahedron_test_top #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	pit_pt_if.sink           pt,
	pit_res_if.source        res
);
	import pit_pkg::*;

	localparam int PW = COORD_WIDTH + FRAC_BITS;
	localparam int MW = (COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS;
	localparam int AW = MW + FRAC_BITS + 2;

	pit_adv_t adv;
	logic     vld_s1;
	logic     vld_s2;
	logic     vld_s3;
	logic     vld_s4;

	logic signed [PW-1:0] p_s2;
	logic signed [PW-1:0] q_s2;
	logic signed [PW-1:0] zs_s2;
	logic signed [AW-1:0] tp_s3;
	logic signed [AW-1:0] tq_s3;
	logic signed [AW-1:0] d1_s3;
	logic signed [AW-1:0] nd1_s3;
	logic signed [AW-1:0] d2_s3;
	logic signed [AW-1:0] nd2_s3;
	logic                 inside_s4;

	assign adv.en_s4 = !vld_s4 || res.ready;
	assign adv.en_s3 = !vld_s3 || adv.en_s4;
	assign adv.en_s2 = !vld_s2 || adv.en_s3;
	assign adv.en_s1 = !vld_s1 || adv.en_s2;

	assign pt.ready = adv.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv.en_s1) begin
				vld_s1 <= pt.valid;
			end
			if (adv.en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv.en_s3) begin
				vld_s3 <= vld_s2;
			end
			if (adv.en_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	pit_prod #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_prod (
		.clk   (clk),
		.adv   (adv),
		.x     (pt.point_x),
		.y     (pt.point_y),
		.z     (pt.point_z),
		.p_s2  (p_s2),
		.q_s2  (q_s2),
		.zs_s2 (zs_s2)
	);

	pit_offs #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.AW          (AW)
	) u_offs (
		.clk    (clk),
		.adv    (adv),
		.p      (p_s2),
		.q      (q_s2),
		.zs     (zs_s2),
		.tp_s3  (tp_s3),
		.tq_s3  (tq_s3),
		.d1_s3  (d1_s3),
		.nd1_s3 (nd1_s3),
		.d2_s3  (d2_s3),
		.nd2_s3 (nd2_s3)
	);

	pit_cmp #(
		.AW (AW)
	) u_cmp (
		.clk       (clk),
		.adv       (adv),
		.tp        (tp_s3),
		.tq        (tq_s3),
		.d1        (d1_s3),
		.nd1       (nd1_s3),
		.d2        (d2_s3),
		.nd2       (nd2_s3),
		.inside_s4 (inside_s4)
	);

	assign res.valid      = vld_s4;
	assign res.inside_res = inside_s4;
endmodule

FILE: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 24;
	localparam int FB = 20;
	localparam longint HALF = longint'(1) << (FB - 1);
	// half-height of the body, rounded to the grid
	localparam longint R_GRID = longint'($rtoi($sqrt(2.0 ** (2 * FB - 3)) + 0.5));
	localparam longint C_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint C_MIN = -(longint'(1) << (CW - 1));
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_LIMIT = 2000;

	typedef logic signed [CW-1:0] coord_t;

	logic clk;
	logic arst_n;

	pit_pt_if #(.COORD_WIDTH(CW)) pt_bus ();
	pit_res_if res_bus ();

	point_in_tetrahedron_test_top #(
		.COORD_WIDTH(CW),
		.FRAC_BITS  (FB)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.pt    (pt_bus),
		.res   (res_bus)
	);

	logic inside_due_q[$];
	int   fails       = 0;
	int   burst_left  = 0;
	int   max_gap     = 0;
	int   stall_pct   = 0;
	bit   hold_req    = 1'b0;
	int   idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sign of the four face forms; all non-negative means inside or on the boundary
	function automatic logic inside_tetra(input coord_t px, input coord_t py, input coord_t pz);
		longint x, y, z;
		longint fa, fb, fc, fd;
		x = px;
		y = py;
		z = pz;
		fa = 2 * R_GRID * (x + HALF) - HALF * (z + R_GRID);
		fb = 2 * R_GRID * (HALF - x) - HALF * (z + R_GRID);
		fc = 2 * R_GRID * (y + HALF) + HALF * (z - R_GRID);
		fd = 2 * R_GRID * (HALF - y) + HALF * (z - R_GRID);
		return (fa >= 0) && (fb >= 0) && (fc >= 0) && (fd >= 0);
	endfunction

	function automatic longint rand_between(input longint lo, input longint hi);
		return lo + longint'($urandom_range(0, int'(hi - lo)));
	endfunction

	task automatic send_point(input longint x, input longint y, input longint z);
		int     gap;
		coord_t cx, cy, cz;
		cx = coord_t'(x);
		cy = coord_t'(y);
		cz = coord_t'(z);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			if (gap > 0) begin
				pt_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pt_bus.valid   <= 1'b1;
		pt_bus.point_x <= cx;
		pt_bus.point_y <= cy;
		pt_bus.point_z <= cz;
		@(posedge clk);
		while (!pt_bus.ready) @(posedge clk);
		inside_due_q.push_back(inside_tetra(cx, cy, cz));
	endtask

	task automatic check_directed_points();
		max_gap   = 2;
		stall_pct = 20;
		send_point(0, 0, 0);
		send_point(HALF, 0, -R_GRID);
		send_point(-HALF, 0, -R_GRID);
		send_point(0, HALF, R_GRID);
		send_point(0, -HALF, R_GRID);
		send_point(HALF + 1, 0, -R_GRID);
		send_point(0, -HALF - 1, R_GRID);
		send_point(0, 0, -R_GRID);
		send_point(0, 0, -R_GRID - 1);
		send_point(0, 0, R_GRID);
		send_point(0, 0, R_GRID + 1);
		send_point(HALF / 2, HALF / 2, 0);
		send_point(-HALF / 2, -HALF / 2, 0);
		send_point(C_MAX, C_MAX, C_MAX);
		send_point(C_MIN, C_MIN, C_MIN);
		send_point(C_MAX, C_MIN, 0);
		send_point(C_MIN, C_MAX, 0);
		send_point(0, 0, C_MAX);
		send_point(0, 0, C_MIN);
		send_point(C_MAX, 0, 0);
		send_point(C_MIN, 0, 0);
		send_point(-1, -1, -1);
	endtask

	task automatic check_full_range_points(input int count);
		max_gap   = 5;
		stall_pct = 40;
		repeat (count) send_point(longint'($urandom()), longint'($urandom()), longint'($urandom()));
	endtask

	task automatic check_points_near_body(input int count);
		longint m;
		max_gap   = 4;
		stall_pct = 30;
		m = HALF / 8;
		repeat (count)
			send_point(rand_between(-HALF - m, HALF + m), rand_between(-HALF - m, HALF + m),
				rand_between(-R_GRID - m, R_GRID + m));
	endtask

	// points right on or one step off a randomly chosen face
	task automatic check_points_on_faces(input int count);
		longint u, w, z, num;
		max_gap   = 3;
		stall_pct = 25;
		repeat (count) begin
			if ($urandom_range(0, 1))
				u = -HALF + (longint'(1) << (FB - 5)) * $urandom_range(0, 32);
			else
				u = rand_between(-HALF, HALF);
			w = rand_between(-HALF / 2, HALF / 2);
			num = 2 * R_GRID * (u + HALF);
			z = num / HALF - R_GRID + $urandom_range(0, 2) - 1;
			case ($urandom_range(0, 3))
				0: send_point(u, w, z);
				1: send_point(-u, w, z);
				2: send_point(w, u, -z);
				default: send_point(w, -u, -z);
			endcase
		end
	endtask

	task automatic check_input_stall_under_hold(input int count);
		max_gap   = 0;
		stall_pct = 0;
		hold_req  = 1'b1;
		repeat (count)
			send_point(rand_between(-HALF, HALF), rand_between(-HALF, HALF),
				rand_between(-R_GRID, R_GRID));
	endtask

	task automatic check_unbroken_streaming(input int count);
		max_gap   = 0;
		stall_pct = 0;
		repeat (count)
			send_point(rand_between(-HALF, HALF), rand_between(-HALF, HALF),
				rand_between(-R_GRID, R_GRID));
	endtask

	initial begin
		arst_n         <= 1'b0;
		pt_bus.valid   <= 1'b0;
		pt_bus.point_x <= '0;
		pt_bus.point_y <= '0;
		pt_bus.point_z <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_directed_points();
		check_full_range_points(350);
		check_points_near_body(450);
		check_input_stall_under_hold(60);
		check_points_on_faces(400);
		check_unbroken_streaming(100);
		pt_bus.valid <= 1'b0;
		while (inside_due_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver: runs of ready/stall, plus a long hold-off on request
	initial begin
		int  hold_left;
		int  run_left;
		bit  run_ready;
		hold_left = 0;
		run_left  = 0;
		run_ready = 1'b1;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left  = $urandom_range(1, 8);
					run_ready = ($urandom_range(0, 99) >= stall_pct);
				end
				run_left--;
				res_bus.ready <= run_ready;
			end
		end
	end

	always @(posedge clk) begin
		logic want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (inside_due_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result beat: inside_res=%b", res_bus.inside_res);
			end else begin
				want = inside_due_q.pop_front();
				if (res_bus.inside_res !== want) begin
					fails++;
					if (fails <= 10)
						$display("inside_res mismatch: expected %b, got %b", want, res_bus.inside_res);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
